// ===== sv/ftfal_pkg.sv =====
// package for the five-tuple flow admission limiter
// holds widths, protocol and verdict codes and the transaction structs
// used by ftfal_cell and five_tuple_flow_admission_limiter_top
`default_nettype none

package ftfal_pkg;

  // field widths
  localparam int ADDR_W  = 32;
  localparam int PROTO_W = 8;
  localparam int PORT_W  = 16;
  localparam int STAMP_W = 64;
  localparam int CNT_W   = 32;
  localparam int LIMIT_W = 7;
  localparam int VERD_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int KEY_W   = 2 * ADDR_W + PROTO_W + 2 * PORT_W;

  // defaults
  localparam int TABLE_DEPTH_DEF = 64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

  // protocol numbers
  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

  // verdict codes
  localparam logic [VERD_W-1:0] VERDICT_PASS    = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_DROP    = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_IGNORED = 2'd2;

  // lookup token walking down the cell chain
  typedef struct packed {
    logic               valid;
    logic               active;
    logic               found;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0]   packets;
  } tok_t;

  // new-entry write broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

endpackage

`default_nettype wire

// ===== sv/ftfal_cell.sv =====
// one flow table slot: stored five-tuple, packet count and last-seen time
// compares the passing lookup token and hands it to the next cell
// depends on ftfal_pkg
`default_nettype none

module ftfal_cell
  import ftfal_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             occupied_i,
  input  wire tok_t             tok_i,
  input  wire logic [IDX_W-1:0] slot_i,
  input  wire wr_t              wr_i,
  input  wire logic [IDX_W-1:0] wr_slot_i,
  output tok_t                  tok_o,
  output logic [IDX_W-1:0]      slot_o
);

  localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(IDX);

  logic [KEY_W-1:0]   key_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [STAMP_W-1:0] stamp_q;
  tok_t               tok_q, tok_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic               hit;
  logic               wr_here;

  // match against this slot, first hit wins
  assign hit = tok_i.valid && tok_i.active && !tok_i.found && occupied_i &&
               (key_q == tok_i.key);
  assign wr_here = wr_i.en && (wr_slot_i == MY_SLOT);

  // saturating count update
  assign count_d = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);

  // token for the next cell
  always_comb begin
    tok_d  = tok_i;
    slot_d = slot_i;
    if (hit) begin
      tok_d.found   = 1'b1;
      tok_d.packets = count_d;
      slot_d        = MY_SLOT;
    end
  end

  // slot contents, written on admission or updated on a hit
  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      key_q   <= wr_i.key;
      count_q <= CNT_W'(1);
      stamp_q <= wr_i.stamp;
    end else if (hit) begin
      count_q <= count_d;
      stamp_q <= tok_i.stamp;
    end
  end

  // token stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      slot_q <= slot_d;
    end
  end

  assign tok_o  = tok_q;
  assign slot_o = slot_q;

endmodule

`default_nettype wire

// ===== sv/five_tuple_flow_admission_limiter_top.sv =====
// five-tuple flow admission limiter: one transaction at a time walks a chain
// of TABLE_DEPTH slot cells, one cell per cycle; the verdict is registered in
// the done state and moves to the output registers once the output is free,
// and a new transaction is taken only after that
// reset clears the flow count, chain token valid bits, out_valid_o and
// sets the flow limit to 64; slot contents are not cleared, no clearing pass
// depends on ftfal_pkg and ftfal_cell
`default_nettype none

module five_tuple_flow_admission_limiter_top
  import ftfal_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ADDR_W-1:0]  src_addr_i,
  input  wire logic [ADDR_W-1:0]  dst_addr_i,
  input  wire logic [PROTO_W-1:0] protocol_i,
  input  wire logic [PORT_W-1:0]  src_port_i,
  input  wire logic [PORT_W-1:0]  dst_port_i,
  input  wire logic [STAMP_W-1:0] arrival_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [VERD_W-1:0]       verdict_o,
  output logic                    admitted_new_o,
  output logic [SLOT_W-1:0]       flow_slot_o,
  output logic [CNT_W-1:0]        flow_packets_o
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HELD_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (HELD_W > LIMIT_W) ? HELD_W : LIMIT_W;
  localparam int SX_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_e;

  state_e              state_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic [HELD_W-1:0]   held_q;
  logic                accept;
  logic                out_free;

  tok_t                tok_in;
  tok_t                chain_tok  [TABLE_DEPTH+1];
  logic [IDX_W-1:0]    chain_slot [TABLE_DEPTH+1];
  tok_t                tail;
  logic [IDX_W-1:0]    tail_slot;
  wr_t                 wr;
  logic [IDX_W-1:0]    wr_slot;

  logic [CMP_W-1:0]    limit_ext, eff_limit, held_ext;
  logic                admit;
  logic [IDX_W-1:0]    slot_sel;
  logic [SX_W-1:0]     slot_x;

  logic [VERD_W-1:0]   res_verdict_q;
  logic                res_new_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [CNT_W-1:0]    res_packets_q;

  // handshakes
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  // lookup token entering the chain
  always_comb begin
    tok_in.valid   = accept;
    tok_in.active  = (protocol_i == PROTO_TCP) || (protocol_i == PROTO_UDP);
    tok_in.found   = 1'b0;
    tok_in.key     = {src_addr_i, dst_addr_i, protocol_i, src_port_i, dst_port_i};
    tok_in.stamp   = arrival_time_i;
    tok_in.packets = '0;
  end

  assign chain_tok[0]  = tok_in;
  assign chain_slot[0] = '0;

  // cell chain, one slot per cell
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam logic [HELD_W-1:0] IDX_H = HELD_W'(i);
    logic occupied;
    assign occupied = IDX_H < held_q;

    ftfal_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .occupied_i (occupied),
      .tok_i      (chain_tok[i]),
      .slot_i     (chain_slot[i]),
      .wr_i       (wr),
      .wr_slot_i  (wr_slot),
      .tok_o      (chain_tok[i+1]),
      .slot_o     (chain_slot[i+1])
    );
  end

  assign tail      = chain_tok[TABLE_DEPTH];
  assign tail_slot = chain_slot[TABLE_DEPTH];

  // admission decision at the end of the chain
  assign limit_ext = CMP_W'(limit_q);
  assign eff_limit = (limit_ext > DEPTH_C) ? DEPTH_C : limit_ext;
  assign held_ext  = CMP_W'(held_q);
  assign admit     = tail.valid && tail.active && !tail.found && (held_ext < eff_limit);

  assign slot_sel = tail.found ? tail_slot : IDX_W'(held_q);
  assign slot_x   = SX_W'(slot_sel);

  // new entry write into the next free slot
  assign wr.en    = admit;
  assign wr.key   = tail.key;
  assign wr.stamp = tail.stamp;
  assign wr_slot  = IDX_W'(held_q);

  // limit register, zero writes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i && (cfg_wdata_i != '0)) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // sequencer, flow count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      // result taken; the done state reloads valid on its own
      if (out_valid_o && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (tail.valid) begin
            state_q <= ST_DONE;
            if (!tail.active) begin
              res_verdict_q <= VERDICT_IGNORED;
              res_new_q     <= 1'b0;
              res_slot_q    <= '0;
              res_packets_q <= '0;
            end else if (tail.found) begin
              res_verdict_q <= VERDICT_PASS;
              res_new_q     <= 1'b0;
              res_slot_q    <= slot_x[SLOT_W-1:0];
              res_packets_q <= tail.packets;
            end else if (admit) begin
              res_verdict_q <= VERDICT_PASS;
              res_new_q     <= 1'b1;
              res_slot_q    <= slot_x[SLOT_W-1:0];
              res_packets_q <= CNT_W'(1);
              held_q        <= held_q + HELD_W'(1);
            end else begin
              res_verdict_q <= VERDICT_DROP;
              res_new_q     <= 1'b0;
              res_slot_q    <= '0;
              res_packets_q <= '0;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q        <= ST_IDLE;
            out_valid_o    <= 1'b1;
            verdict_o      <= res_verdict_q;
            admitted_new_o <= res_new_q;
            flow_slot_o    <= res_slot_q;
            flow_packets_o <= res_packets_q;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_new_is_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && admitted_new_o) |-> (verdict_o == VERDICT_PASS))
    else $error("new flow reported without pass verdict");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CMP_W'(held_q) <= DEPTH_C))
    else $error("flow count above table depth");

  a_held_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != $past(held_q)) |->
      ((state_q == ST_DONE) && res_new_q && (held_q == $past(held_q) + HELD_W'(1))))
    else $error("flow count changed without admission");

  a_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !tail.valid)
    else $error("input taken while a lookup is in the chain");

endmodule

`default_nettype wire
